@@ rtl/sfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants, types and the byte-wide CRC-16 update for the sync frame
// receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // Byte position within a frame, 0 means hunting the first sync byte
   typedef logic [4:0] pos_type;
   typedef logic [7:0] byte_type;
   typedef logic [15:0] crc_type;

   localparam pos_type PosHunt      = 5'd0;
   localparam pos_type PosSync      = 5'd1;
   localparam pos_type PosDataFirst = 5'd2;
   localparam pos_type PosDataLast  = 5'd19;
   localparam pos_type PosCrcLow    = 5'd20;
   localparam pos_type PosCrcHigh   = 5'd21;

   localparam byte_type SyncFirst  = 8'hCD;
   localparam byte_type SyncSecond = 8'hAB;
   localparam crc_type  CrcPoly    = 16'h1021;
   localparam crc_type  CrcInit    = 16'h0000;

   // CRC-16, MSB first, one byte per call
   function automatic crc_type crc16_byte(input crc_type crc, input byte_type data);
      crc_type c;
      c = crc ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

@@ rtl/sync_frame_receiver_crc16.sv @@
`timescale 1ns / 1ps
// The transfer carrying the last frame byte is captured in the input register, and from
// there the frame loads the result register, which then flags a valid result.
// Throughput: one byte per cycle; a byte that completes a frame waits in the input
// register only while the previous result is still held and stalled.
// Reset: synchronous; clears the byte position, running CRC and both valid flags.
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc16
// Hunts for the 0xCD 0xAB sync pair, collects a 22-byte little-endian frame,
// checks its CRC-16 and emits the decoded fields with a CRC match flag.
// ----------------------------------------------------------------------------
module sync_frame_receiver_crc16
   import sfr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_speed_left,
   output logic signed [15:0] rsp_speed_right,
   output logic [15:0]        rsp_setpoint_word,
   output logic signed [15:0] rsp_measured_left,
   output logic signed [15:0] rsp_measured_right,
   output logic signed [31:0] rsp_odometer_left,
   output logic signed [31:0] rsp_odometer_right,
   output logic               rsp_check_ok
);

   logic     in_valid_ff;
   byte_type in_byte_ff;
   pos_type  pos_ff, pos_in;
   crc_type  crc_ff, crc_in;
   byte_type data_ff [PosDataFirst:PosDataLast];
   byte_type crc_low_ff;
   logic     rsp_valid_ff;

   logic     frame_done;
   logic     fire;
   logic     rsp_free;

   // Result register can take a new frame when empty or being drained
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign frame_done = (pos_ff == PosCrcHigh);
   assign fire       = in_valid_ff && (!frame_done || rsp_free);
   assign req_stall  = in_valid_ff && !fire;

   // Capture the incoming transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Advance byte position and running CRC
   always_comb begin
      pos_in = pos_ff;
      crc_in = crc_ff;
      if (pos_ff == PosHunt || pos_ff > PosCrcHigh) begin
         pos_in = PosHunt;
         if (in_byte_ff == SyncFirst) begin
            pos_in = PosSync;
            crc_in = crc16_byte(CrcInit, in_byte_ff);
         end
      end else if (pos_ff == PosSync) begin
         if (in_byte_ff == SyncSecond) begin
            pos_in = PosDataFirst;
            crc_in = crc16_byte(crc_ff, in_byte_ff);
         end else if (in_byte_ff == SyncFirst) begin
            pos_in = PosSync;
            crc_in = crc16_byte(CrcInit, in_byte_ff);
         end else begin
            pos_in = PosHunt;
            crc_in = CrcInit;
         end
      end else if (frame_done) begin
         pos_in = PosHunt;
         crc_in = CrcInit;
      end else begin
         pos_in = pos_ff + 5'd1;
         if (pos_ff <= PosDataLast) begin
            crc_in = crc16_byte(crc_ff, in_byte_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= PosHunt;
         crc_ff <= CrcInit;
      end else if (fire) begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // Store payload bytes and the low CRC byte
   always_ff @(posedge clock) begin
      if (fire) begin
         if (pos_ff inside {[PosDataFirst:PosDataLast]}) begin
            data_ff[pos_ff] <= in_byte_ff;
         end
         if (pos_ff == PosCrcLow) begin
            crc_low_ff <= in_byte_ff;
         end
      end
   end

   // Hold the result until the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && frame_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Load the decoded fields
   always_ff @(posedge clock) begin
      if (fire && frame_done) begin
         rsp_speed_left     <= signed'({data_ff[3], data_ff[2]});
         rsp_speed_right    <= signed'({data_ff[5], data_ff[4]});
         rsp_setpoint_word  <= {data_ff[7], data_ff[6]};
         rsp_measured_left  <= signed'({data_ff[9], data_ff[8]});
         rsp_measured_right <= signed'({data_ff[11], data_ff[10]});
         rsp_odometer_left  <= signed'({data_ff[15], data_ff[14], data_ff[13], data_ff[12]});
         rsp_odometer_right <= signed'({data_ff[19], data_ff[18], data_ff[17], data_ff[16]});
         rsp_check_ok       <= ({in_byte_ff, crc_low_ff} == crc_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // Position never leaves the frame range
   assert property (@(posedge clock) disable iff (reset) pos_ff <= PosCrcHigh)
      else $error("byte position out of range");

   // Hunting always starts from a clean CRC
   assert property (@(posedge clock) disable iff (reset) pos_ff == PosHunt |-> crc_ff == CrcInit)
      else $error("CRC not cleared while hunting");

   // A finished frame shows up as a valid result next cycle
   assert property (@(posedge clock) disable iff (reset) fire && frame_done |=> rsp_valid_ff)
      else $error("completed frame lost");

   // A held, stalled result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !(fire && frame_done))
      else $error("stalled result overwritten");

   // Input only stalls when a byte is waiting
   assert property (@(posedge clock) disable iff (reset) req_stall |-> in_valid_ff && frame_done)
      else $error("input stalled without a pending frame end");

endmodule
